### sv/lpta_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpta_pkg
// Shared types and constants for the scan measurement decoder.
// ----------------------------------------------------------------------------
package lpta_pkg;

	localparam int TABLE_SIZE = 360;
	localparam int MEAS_BYTES = 5;
	localparam int ANGLE_W    = 9;
	localparam int RANGE_W    = 16;
	localparam int QUAL_W     = 6;
	localparam int APB_AW     = 4;
	localparam int APB_DW     = 32;

	localparam logic [RANGE_W-1:0] RESET_DISTANCE = 16'd40000;
	localparam logic [QUAL_W-1:0]  RESET_QUAL_THR = 6'd1;
	localparam logic [RANGE_W-1:0] RESET_FLOOR    = 16'd40;

	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	localparam logic KIND_MEAS = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [1:0] REG_QUAL_THR = 2'd0;
	localparam logic [1:0] REG_FLOOR    = 2'd1;
	localparam logic [1:0] REG_DEFAULT  = 2'd2;

	typedef struct packed {
		logic [QUAL_W-1:0]  qual_thr;
		logic [RANGE_W-1:0] distance_floor;
		logic [RANGE_W-1:0] dflt_range;
	} cfg_t;

	typedef struct packed {
		logic               kind;
		logic [ANGLE_W-1:0] angle;
		logic [RANGE_W-1:0] range;
		logic [QUAL_W-1:0]  quality;
		logic               live;
	} op_t;

endpackage
`default_nettype wire

### sv/lpta_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpta_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lpta_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 360
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### sv/lpta_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpta_front
// Takes input beats, skips the response header, assembles 5-byte
// measurements, decodes quality/angle/range and emits table operations.
// ----------------------------------------------------------------------------
module lpta_front #(
	parameter int HEADER_BYTES = 7
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           func,
	input  wire logic [7:0]                     rx_byte,
	input  wire logic [lpta_pkg::ANGLE_W-1:0]   read_angle,
	input  wire lpta_pkg::cfg_t                 cfg,
	input  wire logic                           back_busy,
	input  wire logic                           q_ready,
	output logic                                q_push,
	output lpta_pkg::op_t                       q_op
);

	logic [3:0] header_q;
	logic [2:0] pos_q;
	logic [7:0] pkt_q [4];
	logic       live_q;

	logic                             accept;
	logic                             hdr_done;
	logic                             last_byte;
	logic [lpta_pkg::QUAL_W-1:0]      qual;
	logic [lpta_pkg::ANGLE_W-1:0]     a_raw;
	logic [lpta_pkg::ANGLE_W-1:0]     a_mod;
	logic [lpta_pkg::ANGLE_W-1:0]     ang;
	logic [lpta_pkg::RANGE_W-1:0]     rng;
	logic                             reject;

	assign in_ready  = q_ready && !back_busy;
	assign accept    = in_valid && in_ready;
	assign hdr_done  = !(header_q < 4'(HEADER_BYTES));
	assign last_byte = (pos_q == 3'(lpta_pkg::MEAS_BYTES - 1));

	assign qual  = pkt_q[0][7:2];
	assign a_raw = {pkt_q[2], pkt_q[1][7]};
	assign a_mod = (a_raw >= 9'(lpta_pkg::TABLE_SIZE)) ?
		a_raw - 9'(lpta_pkg::TABLE_SIZE) : a_raw;
	assign ang   = (a_mod == '0) ? '0 : 9'(lpta_pkg::TABLE_SIZE) - a_mod;
	assign rng   = {rx_byte, pkt_q[3]};
	assign reject = (qual < cfg.qual_thr) || (rng < cfg.distance_floor);

	always_comb begin
		q_push = 1'b0;
		q_op   = '0;
		if (func == lpta_pkg::FUNC_READ) begin
			q_push     = accept;
			q_op.kind  = lpta_pkg::KIND_READ;
			q_op.angle = read_angle;
			q_op.live  = live_q;
		end else begin
			q_push       = accept && hdr_done && last_byte;
			q_op.kind    = lpta_pkg::KIND_MEAS;
			q_op.angle   = ang;
			q_op.range   = reject ? cfg.dflt_range : rng;
			q_op.quality = qual;
			q_op.live    = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= '0;
			pos_q    <= '0;
			live_q   <= 1'b0;
		end else if (accept && func == lpta_pkg::FUNC_BYTE) begin
			if (!hdr_done) begin
				header_q <= header_q + 4'd1;
			end else if (!last_byte) begin
				pos_q <= pos_q + 3'd1;
			end else begin
				pos_q  <= '0;
				live_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && func == lpta_pkg::FUNC_BYTE && hdr_done && !last_byte) begin
			pkt_q[pos_q[1:0]] <= rx_byte;
		end
	end

endmodule
`default_nettype wire

### sv/lpta_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpta_queue
// Two-entry operation queue between front and back.
// ----------------------------------------------------------------------------
module lpta_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire lpta_pkg::op_t push_op,
	output logic               ready,
	input  wire logic          pop,
	output logic               valid,
	output lpta_pkg::op_t      head
);

	lpta_pkg::op_t ent_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;

	assign ready = (cnt_q != 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign head  = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_op;
		end
	end

endmodule
`default_nettype wire

### sv/lpta_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpta_back
// Executes table writes and reads against the range table RAM, clears the
// table after reset and holds the result beat in an output register.
// ----------------------------------------------------------------------------
module lpta_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [lpta_pkg::RANGE_W-1:0] dflt_range,
	input  wire logic                         q_valid,
	input  wire lpta_pkg::op_t                q_head,
	output logic                              q_pop,
	output logic                              busy,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output lpta_pkg::op_t                     out_op
);

	localparam int AW = $clog2(lpta_pkg::TABLE_SIZE);

	logic          clr_q;
	logic [AW-1:0] clr_addr_q;

	logic          valid_s1;
	lpta_pkg::op_t op_s1;
	logic          inrange_s1;

	logic          out_valid_q;
	lpta_pkg::op_t out_q;

	logic                          adv_s1;
	logic                          head_inrange;
	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	logic [lpta_pkg::RANGE_W-1:0]  ram_wdata;
	logic                          ram_re;
	logic [lpta_pkg::RANGE_W-1:0]  ram_rdata;
	lpta_pkg::op_t                 res;

	assign busy         = clr_q;
	assign adv_s1       = valid_s1 && (!out_valid_q || out_ready);
	assign q_pop        = !clr_q && q_valid && (!valid_s1 || adv_s1);
	assign head_inrange = (q_head.angle < 9'(lpta_pkg::TABLE_SIZE));
	assign ram_re       = q_pop && q_head.kind == lpta_pkg::KIND_READ && head_inrange;

	always_comb begin
		if (clr_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = lpta_pkg::RESET_DISTANCE;
		end else begin
			ram_we    = q_pop && q_head.kind == lpta_pkg::KIND_MEAS;
			ram_waddr = q_head.angle[AW-1:0];
			ram_wdata = q_head.range;
		end
	end

	lpta_ram #(
		.WIDTH(lpta_pkg::RANGE_W),
		.DEPTH(lpta_pkg::TABLE_SIZE)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(q_head.angle[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_comb begin
		res = op_s1;
		if (op_s1.kind == lpta_pkg::KIND_READ) begin
			res.range = inrange_s1 ? ram_rdata : dflt_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= 1'b1;
			clr_addr_q  <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == AW'(lpta_pkg::TABLE_SIZE - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (q_pop) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_s1      <= q_head;
			inrange_s1 <= head_inrange;
		end
		if (adv_s1) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_op    = out_q;

endmodule
`default_nettype wire

### sv/lidar_packet_to_angle_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_packet_to_angle_table
// Scan measurement decoder with a 360-entry range table.
//
// Input channel (in_valid/in_ready): func 0 carries one received serial byte
// in rx_byte, func 1 asks for the table entry at read_angle. After reset the
// first HEADER_BYTES bytes are dropped once; then every five bytes make one
// measurement, which is written to the table and reported (result_kind 0).
// A read beat returns the entry with the live flag (result_kind 1); angles
// 360..511 return the current default distance.
// Output channel (out_valid/out_ready) carries one result beat per
// measurement or read. A result passes the queue entry, stage s1 and the
// output register before out_valid; one beat per cycle is sustained while
// out_ready stays high and no clear runs, one table port per operation.
// Reset: config returns to its reset values and the table is cleared to
// 40000 by a pass over all entries, while in_ready stays low. APB is usable
// at all times.
// When the receiver stalls, the output register, one stage and a two-entry
// queue fill before in_ready drops.
// ----------------------------------------------------------------------------
module lidar_packet_to_angle_table #(
	parameter int HEADER_BYTES = 7
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            func,
	input  wire logic [7:0]                      rx_byte,
	input  wire logic [lpta_pkg::ANGLE_W-1:0]    read_angle,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 result_kind,
	output logic      [lpta_pkg::ANGLE_W-1:0]    angle_deg,
	output logic      [lpta_pkg::RANGE_W-1:0]    range_raw,
	output logic      [lpta_pkg::QUAL_W-1:0]     quality_level,
	output logic                                 live_data,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [lpta_pkg::APB_AW-1:0]     paddr,
	input  wire logic [lpta_pkg::APB_DW-1:0]     pwdata,
	output logic      [lpta_pkg::APB_DW-1:0]     prdata,
	output logic                                 pready
);

	lpta_pkg::cfg_t cfg_q;
	logic           cfg_wr;
	logic           busy;
	logic           q_ready;
	logic           q_push;
	lpta_pkg::op_t  q_op;
	logic           q_pop;
	logic           q_valid;
	lpta_pkg::op_t  q_head;
	lpta_pkg::op_t  out_op;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.qual_thr       <= lpta_pkg::RESET_QUAL_THR;
			cfg_q.distance_floor <= lpta_pkg::RESET_FLOOR;
			cfg_q.dflt_range     <= lpta_pkg::RESET_DISTANCE;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				lpta_pkg::REG_QUAL_THR: begin
					cfg_q.qual_thr <= pwdata[lpta_pkg::QUAL_W-1:0];
				end
				lpta_pkg::REG_FLOOR: begin
					cfg_q.distance_floor <= pwdata[lpta_pkg::RANGE_W-1:0];
				end
				lpta_pkg::REG_DEFAULT: begin
					cfg_q.dflt_range <= pwdata[lpta_pkg::RANGE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			lpta_pkg::REG_QUAL_THR: prdata = 32'(cfg_q.qual_thr);
			lpta_pkg::REG_FLOOR:    prdata = 32'(cfg_q.distance_floor);
			lpta_pkg::REG_DEFAULT:  prdata = 32'(cfg_q.dflt_range);
			default:                prdata = '0;
		endcase
	end

	lpta_front #(
		.HEADER_BYTES(HEADER_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.rx_byte   (rx_byte),
		.read_angle(read_angle),
		.cfg       (cfg_q),
		.back_busy (busy),
		.q_ready   (q_ready),
		.q_push    (q_push),
		.q_op      (q_op)
	);

	lpta_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.push_op(q_op),
		.ready  (q_ready),
		.pop    (q_pop),
		.valid  (q_valid),
		.head   (q_head)
	);

	lpta_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.dflt_range(cfg_q.dflt_range),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.busy      (busy),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_op    (out_op)
	);

	assign result_kind   = out_op.kind;
	assign angle_deg     = out_op.angle;
	assign range_raw     = out_op.range;
	assign quality_level = out_op.quality;
	assign live_data     = out_op.live;

endmodule
`default_nettype wire
